// ===== rtl/grid_bilinear_mapper_top_assert.svh =====
// ----------------------------------------------------------------------------
// Grid bilinear mapper assertion macros
// Concurrent assertion wrappers; defining ASSERT_OFF turns them into nothing.
// ----------------------------------------------------------------------------
`ifndef GRID_BILINEAR_MAPPER_TOP_ASSERT_SVH
`define GRID_BILINEAR_MAPPER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define GBM_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define GBM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define GBM_ASSERT_SAME(label, clk, rst_n, pre, post, msg)
`define GBM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== rtl/gbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid bilinear mapper package
// Command and status codes, sequencer types and datapath widths.
// ----------------------------------------------------------------------------
package gbm_pkg;

    typedef enum logic [1:0] {
        CMD_ROW_POS = 2'd0,
        CMD_COL_POS = 2'd1,
        CMD_NODE    = 2'd2,
        CMD_EVAL    = 2'd3
    } cmd_t;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_ZERO = 2'd1;
    localparam logic [1:0] STATUS_SAT  = 2'd2;

    localparam logic [0:0] CFG_ROW_COUNT = 1'b0;
    localparam logic [0:0] CFG_COL_COUNT = 1'b1;

    localparam int COORD_W = 24;
    localparam int NODE_W  = 32;
    localparam int CNT_W   = 7;
    localparam int SPACE_W = 16;
    localparam int OPA_W   = 34;
    localparam int DIGIT_W = 17;
    localparam int OPB_W   = 3 * DIGIT_W;
    localparam int PROD_W  = OPA_W + DIGIT_W;
    localparam int ACC_W   = 96;
    localparam int QUO_W   = 34;

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_SEARCH  = 12'b0000_0000_0010,
        ST_SDRAIN  = 12'b0000_0000_0100,
        ST_UV      = 12'b0000_0000_1000,
        ST_CORNER  = 12'b0000_0001_0000,
        ST_MAC     = 12'b0000_0010_0000,
        ST_PREP    = 12'b0000_0100_0000,
        ST_DIVINIT = 12'b0000_1000_0000,
        ST_DIVCHK  = 12'b0001_0000_0000,
        ST_DIV     = 12'b0010_0000_0000,
        ST_FIN     = 12'b0100_0000_0000,
        ST_DONE    = 12'b1000_0000_0000
    } state_t;

    typedef enum logic [2:0] {
        JOB_DXY = 3'd0,
        JOB_P1  = 3'd1,
        JOB_P2  = 3'd2,
        JOB_P3  = 3'd3,
        JOB_T1  = 3'd4,
        JOB_T2  = 3'd5,
        JOB_T3  = 3'd6
    } job_t;

endpackage

// ===== rtl/gbm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, a read or a write (which also reads the old word); read data is registered.
// ----------------------------------------------------------------------------
module gbm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/grid_bilinear_mapper_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid bilinear mapper
// Maps output-space points to input space through a stored interpolation grid.
// ----------------------------------------------------------------------------
// Usage: the input channel carries commands. Row position, column position and
// node writes give no result and leave the input ready. An evaluate transfer
// produces exactly one result transfer on the output channel.
// Configuration registers row_count and col_count are written through the
// cfg_we / cfg_index / cfg_data port; the user must write them only while the
// block is idle, which the block itself does not enforce. An evaluate runs in
// steps: the cell search walks both position memories one entry per cycle; the
// four corners are read one per cycle; one 34x17 multiply-accumulate unit forms
// all products, four up front and the three terms per coordinate, and a
// restoring divider gives each coordinate's rounded quotient. A zero grid
// spacing skips all of that and goes straight to the final state.
// The block accepts no input while an evaluate is in flight (in_ready low).
// The result sits in an output register; a stalled receiver only holds the
// block in its final state once a second result is ready to be loaded.
// Reset sets both counts to 2 and empties the output register; the grid
// memories hold garbage until they are written.
// ----------------------------------------------------------------------------
`include "grid_bilinear_mapper_top_assert.svh"

module grid_bilinear_mapper_top #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [0:0]                          cfg_index,
    input  logic [gbm_pkg::CNT_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          command,
    input  logic [5:0]                          row_index,
    input  logic [5:0]                          col_index,
    input  logic [gbm_pkg::COORD_W-1:0]         out_coord_y,
    input  logic [gbm_pkg::COORD_W-1:0]         out_coord_x,
    input  logic signed [gbm_pkg::NODE_W-1:0]   node_sample,
    input  logic signed [gbm_pkg::NODE_W-1:0]   node_line,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [gbm_pkg::NODE_W-1:0]   mapped_x,
    output logic signed [gbm_pkg::NODE_W-1:0]   mapped_y,
    output logic [1:0]                          status
);

    import gbm_pkg::*;

    localparam int RIW = $clog2(MAX_ROWS);
    localparam int CIW = $clog2(MAX_COLS);
    localparam int KW  = (RIW > CIW) ? RIW : CIW;
    localparam int NAW = RIW + CIW;
    localparam int NODE_DEPTH = 1 << NAW;

    localparam logic signed [NODE_W-1:0] NODE_MAX = {1'b0, {(NODE_W-1){1'b1}}};
    localparam logic signed [NODE_W-1:0] NODE_MIN = {1'b1, {(NODE_W-1){1'b0}}};

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    cmd_t   cmd;
    logic   in_fire;
    logic   eval_fire;

    logic [CNT_W-1:0]   row_count_reg, col_count_reg;
    logic [COORD_W-1:0] rpos0_reg, rpos1_reg, cpos0_reg, cpos1_reg;
    logic [COORD_W-1:0] x_reg, y_reg;

    logic [RIW-1:0] rlim_reg, rlim_next;
    logic [CIW-1:0] clim_reg, clim_next;
    logic [KW-1:0]  last_reg, last_next;
    logic [KW-1:0]  k_reg, chk_k_reg;
    logic           chk_row_reg, chk_col_reg;

    logic [RIW-1:0]     row_reg;
    logic [CIW-1:0]     col_reg;
    logic [COORD_W-1:0] rowpos_reg, colpos_reg;

    logic [COORD_W:0]   dx_diff, dy_diff, dx_abs, dy_abs;
    logic [SPACE_W-1:0] mag_dx_next, mag_dy_next;
    logic [SPACE_W-1:0] mag_dx_reg, mag_dy_reg;
    logic               sx_reg, sy_reg, zero_reg;

    logic [COORD_W:0]   u_diff, v_diff, u_abs, v_abs;
    logic [COORD_W-1:0] mag_u_reg, mag_v_reg;
    logic               su_reg, sv_reg;

    logic [2:0]            cnt_reg;
    logic [RIW-1:0]        corner_row;
    logic [CIW-1:0]        corner_col;
    logic [1:0]            corner_idx;
    logic signed [NODE_W-1:0] samp_c_reg [4];
    logic signed [NODE_W-1:0] line_c_reg [4];
    logic                  coord_reg;

    logic signed [NODE_W-1:0] c_tl, c_tr, c_bl, c_br;
    logic [NODE_W:0]       a_diff, b_diff, a_abs, b_abs;
    logic [NODE_W+2:0]     d_diff, d_abs;
    logic [OPA_W-1:0]      absa_reg, absb_reg, absd_reg;
    logic                  sa_reg, sb_reg, sd_reg;

    job_t               job_reg, job_next;
    logic [1:0]         dig_reg;
    logic               ph_reg;
    logic [OPA_W-1:0]   op_a;
    logic [OPB_W-1:0]   op_b;
    logic [DIGIT_W-1:0] digit;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  prod_reg;
    logic [5:0]         shamt;
    logic               term_neg;
    logic [ACC_W-1:0]   shifted, acc_base, acc_sum, acc_reg, acc_mag;
    logic [31:0]        dxy_reg;
    logic [39:0]        p1_reg, p2_reg;
    logic [47:0]        p3_reg;
    logic               mac_last;

    logic [ACC_W-1:0] den, half, m_reg, dsh_reg;
    logic             div_ge;
    logic             neg_reg, ovf_reg;
    logic [QUO_W-1:0] q_reg;
    logic [5:0]       dcnt_reg;

    logic                     fin_s, fin_pos, fin_neg, fin_sat;
    logic signed [NODE_W-1:0] fin_tl, fin_val;
    logic [QUO_W+1:0]         q_ext, tl_ext, r_ext;
    logic signed [NODE_W-1:0] mx_reg, my_reg;
    logic                     sat_reg;

    logic                     out_valid_reg;
    logic signed [NODE_W-1:0] mapped_x_reg, mapped_y_reg;
    logic [1:0]               status_reg;
    logic                     out_load;

    logic               row_we, col_we, node_we;
    logic [RIW-1:0]     row_addr;
    logic [CIW-1:0]     col_addr;
    logic [NAW-1:0]     node_addr;
    logic [COORD_W-1:0] row_rdata, col_rdata;
    logic [NODE_W-1:0]  nsamp_rdata, nline_rdata;

    // ------------------------------------------------------------------
    // Handshake and memory ports
    // ------------------------------------------------------------------
    assign cmd       = cmd_t'(command);
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign eval_fire = in_fire && (cmd == CMD_EVAL);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    assign row_we  = in_fire && (cmd == CMD_ROW_POS) && (32'(row_index) < MAX_ROWS);
    assign col_we  = in_fire && (cmd == CMD_COL_POS) && (32'(col_index) < MAX_COLS);
    assign node_we = in_fire && (cmd == CMD_NODE) && (32'(row_index) < MAX_ROWS)
                     && (32'(col_index) < MAX_COLS);

    // The corner counter walks top-left, top-right, bottom-left, bottom-right.
    assign corner_row = row_reg + RIW'(cnt_reg[1]);
    assign corner_col = col_reg + CIW'(cnt_reg[0]);
    assign corner_idx = cnt_reg[1:0] - 2'd1;

    assign row_addr  = (state_reg == ST_IDLE) ? RIW'(row_index) : RIW'(k_reg);
    assign col_addr  = (state_reg == ST_IDLE) ? CIW'(col_index) : CIW'(k_reg);
    assign node_addr = (state_reg == ST_IDLE) ? {RIW'(row_index), CIW'(col_index)}
                                              : {corner_row, corner_col};

    gbm_ram #(.WIDTH(COORD_W), .DEPTH(MAX_ROWS)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .addr  (row_addr),
        .wdata (out_coord_y),
        .rdata (row_rdata)
    );

    gbm_ram #(.WIDTH(COORD_W), .DEPTH(MAX_COLS)) u_col_ram (
        .clk   (clk),
        .we    (col_we),
        .addr  (col_addr),
        .wdata (out_coord_x),
        .rdata (col_rdata)
    );

    gbm_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_samp_ram (
        .clk   (clk),
        .we    (node_we),
        .addr  (node_addr),
        .wdata (node_sample),
        .rdata (nsamp_rdata)
    );

    gbm_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_line_ram (
        .clk   (clk),
        .we    (node_we),
        .addr  (node_addr),
        .wdata (node_line),
        .rdata (nline_rdata)
    );

    // ------------------------------------------------------------------
    // Evaluate setup: spacing from the first two positions, search limits
    // ------------------------------------------------------------------
    always_comb
    begin
        int rc_i;
        int cc_i;
        rc_i = int'(row_count_reg);
        cc_i = int'(col_count_reg);
        if (rc_i < 2)
        begin
            rc_i = 2;
        end
        if (rc_i > MAX_ROWS)
        begin
            rc_i = MAX_ROWS;
        end
        if (cc_i < 2)
        begin
            cc_i = 2;
        end
        if (cc_i > MAX_COLS)
        begin
            cc_i = MAX_COLS;
        end
        rlim_next = RIW'(rc_i - 2);
        clim_next = CIW'(cc_i - 2);
        last_next = (rc_i > cc_i) ? KW'(rc_i - 2) : KW'(cc_i - 2);

        // Truncation toward zero: divide the magnitude and keep the sign.
        dx_diff     = {1'b0, cpos1_reg} - {1'b0, cpos0_reg};
        dy_diff     = {1'b0, rpos1_reg} - {1'b0, rpos0_reg};
        dx_abs      = dx_diff[COORD_W] ? (~dx_diff + 1'b1) : dx_diff;
        dy_abs      = dy_diff[COORD_W] ? (~dy_diff + 1'b1) : dy_diff;
        mag_dx_next = dx_abs[COORD_W-1:8];
        mag_dy_next = dy_abs[COORD_W-1:8];
    end

    assign u_diff = {1'b0, x_reg} - {1'b0, colpos_reg};
    assign v_diff = {1'b0, y_reg} - {1'b0, rowpos_reg};
    assign u_abs  = u_diff[COORD_W] ? (~u_diff + 1'b1) : u_diff;
    assign v_abs  = v_diff[COORD_W] ? (~v_diff + 1'b1) : v_diff;

    // ------------------------------------------------------------------
    // Corner differences for the coordinate being worked on
    // ------------------------------------------------------------------
    always_comb
    begin
        if (coord_reg)
        begin
            c_tl = line_c_reg[0];
            c_tr = line_c_reg[1];
            c_bl = line_c_reg[2];
            c_br = line_c_reg[3];
        end
        else
        begin
            c_tl = samp_c_reg[0];
            c_tr = samp_c_reg[1];
            c_bl = samp_c_reg[2];
            c_br = samp_c_reg[3];
        end
        a_diff = {c_tr[NODE_W-1], c_tr} - {c_tl[NODE_W-1], c_tl};
        b_diff = {c_bl[NODE_W-1], c_bl} - {c_tl[NODE_W-1], c_tl};
        d_diff = {{3{c_br[NODE_W-1]}}, c_br} - {{3{c_tr[NODE_W-1]}}, c_tr}
               - {{3{c_bl[NODE_W-1]}}, c_bl} + {{3{c_tl[NODE_W-1]}}, c_tl};
        a_abs  = a_diff[NODE_W] ? (~a_diff + 1'b1) : a_diff;
        b_abs  = b_diff[NODE_W] ? (~b_diff + 1'b1) : b_diff;
        d_abs  = d_diff[NODE_W+2] ? (~d_diff + 1'b1) : d_diff;
    end

    // ------------------------------------------------------------------
    // Shared multiply-accumulate unit
    // The B operand is taken 17 bits at a time; a product is registered and
    // added into the accumulator on the following cycle.
    // ------------------------------------------------------------------
    always_comb
    begin
        case (job_reg)
            JOB_DXY:
            begin
                op_a = OPA_W'(mag_dx_reg);
                op_b = OPB_W'(mag_dy_reg);
            end
            JOB_P1:
            begin
                op_a = OPA_W'(mag_u_reg);
                op_b = OPB_W'(mag_dy_reg);
            end
            JOB_P2:
            begin
                op_a = OPA_W'(mag_v_reg);
                op_b = OPB_W'(mag_dx_reg);
            end
            JOB_P3:
            begin
                op_a = OPA_W'(mag_u_reg);
                op_b = OPB_W'(mag_v_reg);
            end
            JOB_T1:
            begin
                op_a = absa_reg;
                op_b = OPB_W'(p1_reg);
            end
            JOB_T2:
            begin
                op_a = absb_reg;
                op_b = OPB_W'(p2_reg);
            end
            JOB_T3:
            begin
                op_a = absd_reg;
                op_b = OPB_W'(p3_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase

        case (dig_reg)
            2'd0:    digit = op_b[DIGIT_W-1:0];
            2'd1:    digit = op_b[2*DIGIT_W-1:DIGIT_W];
            2'd2:    digit = op_b[3*DIGIT_W-1:2*DIGIT_W];
            default: digit = '0;
        endcase

        case (dig_reg)
            2'd0:    shamt = 6'd0;
            2'd1:    shamt = 6'(DIGIT_W);
            2'd2:    shamt = 6'(2 * DIGIT_W);
            default: shamt = 6'd0;
        endcase
        // The edge terms T1 and T2 carry an extra factor of 256.
        if (job_reg == JOB_T1 || job_reg == JOB_T2)
        begin
            shamt = shamt + 6'd8;
        end

        case (job_reg)
            JOB_T1:  term_neg = sa_reg ^ su_reg ^ sy_reg;
            JOB_T2:  term_neg = sb_reg ^ sv_reg ^ sx_reg;
            JOB_T3:  term_neg = sd_reg ^ su_reg ^ sv_reg;
            default: term_neg = 1'b0;
        endcase

        case (job_reg)
            JOB_DXY: job_next = JOB_P1;
            JOB_P1:  job_next = JOB_P2;
            JOB_P2:  job_next = JOB_P3;
            JOB_P3:  job_next = JOB_T1;
            JOB_T1:  job_next = JOB_T2;
            JOB_T2:  job_next = JOB_T3;
            JOB_T3:  job_next = JOB_T1;
            default: job_next = JOB_DXY;
        endcase

        prod     = PROD_W'(op_a) * PROD_W'(digit);
        shifted  = ACC_W'(prod_reg) << shamt;
        // Every job but the second and third terms starts from zero.
        acc_base = ((dig_reg == 2'd0) && (job_reg != JOB_T2) && (job_reg != JOB_T3))
                   ? '0 : acc_reg;
        acc_sum  = term_neg ? (acc_base - shifted) : (acc_base + shifted);
        mac_last = (state_reg == ST_MAC) && ph_reg && (dig_reg == 2'd2);
    end

    // ------------------------------------------------------------------
    // Rounding divider and final sum
    // ------------------------------------------------------------------
    assign den     = ACC_W'(dxy_reg) << 16;
    assign half    = ACC_W'(dxy_reg) << 15;
    assign acc_mag = acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign div_ge  = (m_reg >= dsh_reg);

    always_comb
    begin
        fin_tl  = coord_reg ? line_c_reg[0] : samp_c_reg[0];
        fin_s   = neg_reg ^ sx_reg ^ sy_reg;
        q_ext   = {2'b00, q_reg};
        tl_ext  = {{(QUO_W+2-NODE_W){fin_tl[NODE_W-1]}}, fin_tl};
        r_ext   = fin_s ? (tl_ext - q_ext) : (tl_ext + q_ext);
        fin_pos = !r_ext[QUO_W+1] && (r_ext[QUO_W+1:NODE_W-1] != '0);
        fin_neg = r_ext[QUO_W+1] && (r_ext[QUO_W+1:NODE_W-1] != '1);
        fin_sat = ovf_reg || fin_pos || fin_neg;
        if (ovf_reg)
        begin
            fin_val = fin_s ? NODE_MIN : NODE_MAX;
        end
        else if (fin_pos)
        begin
            fin_val = NODE_MAX;
        end
        else if (fin_neg)
        begin
            fin_val = NODE_MIN;
        end
        else
        begin
            fin_val = r_ext[NODE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (eval_fire)
                begin
                    if ((mag_dx_next == '0) || (mag_dy_next == '0))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (k_reg == last_reg)
                begin
                    state_next = ST_SDRAIN;
                end
            end
            ST_SDRAIN:  state_next = ST_UV;
            ST_UV:      state_next = ST_CORNER;
            ST_CORNER:
            begin
                if (cnt_reg == 3'd4)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (mac_last)
                begin
                    if (job_reg == JOB_P3)
                    begin
                        state_next = ST_PREP;
                    end
                    else if (job_reg == JOB_T3)
                    begin
                        state_next = ST_DIVINIT;
                    end
                end
            end
            ST_PREP:    state_next = ST_MAC;
            ST_DIVINIT: state_next = ST_DIVCHK;
            ST_DIVCHK:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (dcnt_reg == 6'(QUO_W - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:     state_next = coord_reg ? ST_DONE : ST_PREP;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_count_reg <= CNT_W'(2);
            col_count_reg <= CNT_W'(2);
            k_reg         <= '0;
            chk_k_reg     <= '0;
            chk_row_reg   <= 1'b0;
            chk_col_reg   <= 1'b0;
            cnt_reg       <= '0;
            job_reg       <= JOB_DXY;
            dig_reg       <= '0;
            ph_reg        <= 1'b0;
            dcnt_reg      <= '0;
            coord_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ROW_COUNT: row_count_reg <= cfg_data;
                    CFG_COL_COUNT: col_count_reg <= cfg_data;
                    default:       ;
                endcase
            end

            if (eval_fire)
            begin
                k_reg <= '0;
            end
            else if (state_reg == ST_SEARCH)
            begin
                k_reg <= k_reg + 1'b1;
            end
            chk_row_reg <= (state_reg == ST_SEARCH) && (k_reg <= KW'(rlim_reg));
            chk_col_reg <= (state_reg == ST_SEARCH) && (k_reg <= KW'(clim_reg));
            chk_k_reg   <= k_reg;

            if (state_reg == ST_CORNER)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
            else
            begin
                cnt_reg <= '0;
            end

            if (eval_fire)
            begin
                job_reg <= JOB_DXY;
                dig_reg <= '0;
                ph_reg  <= 1'b0;
            end
            else if (state_reg == ST_MAC)
            begin
                ph_reg <= ~ph_reg;
                if (ph_reg)
                begin
                    dig_reg <= (dig_reg == 2'd2) ? 2'd0 : (dig_reg + 2'd1);
                end
                if (mac_last)
                begin
                    job_reg <= job_next;
                end
            end

            if (state_reg == ST_DIV)
            begin
                dcnt_reg <= dcnt_reg + 6'd1;
            end
            else
            begin
                dcnt_reg <= '0;
            end

            if (eval_fire)
            begin
                coord_reg <= 1'b0;
            end
            else if (state_reg == ST_FIN)
            begin
                coord_reg <= 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        // Shadow copies of the first two positions give the spacing at once.
        if (row_we && (row_index == 6'd0))
        begin
            rpos0_reg <= out_coord_y;
        end
        if (row_we && (row_index == 6'd1))
        begin
            rpos1_reg <= out_coord_y;
        end
        if (col_we && (col_index == 6'd0))
        begin
            cpos0_reg <= out_coord_x;
        end
        if (col_we && (col_index == 6'd1))
        begin
            cpos1_reg <= out_coord_x;
        end

        if (eval_fire)
        begin
            x_reg      <= out_coord_x;
            y_reg      <= out_coord_y;
            rlim_reg   <= rlim_next;
            clim_reg   <= clim_next;
            last_reg   <= last_next;
            mag_dx_reg <= mag_dx_next;
            mag_dy_reg <= mag_dy_next;
            sx_reg     <= dx_diff[COORD_W];
            sy_reg     <= dy_diff[COORD_W];
            zero_reg   <= (mag_dx_next == '0) || (mag_dy_next == '0);
            row_reg    <= '0;
            col_reg    <= '0;
            rowpos_reg <= rpos0_reg;
            colpos_reg <= cpos0_reg;
        end
        else
        begin
            // The last entry strictly below the point wins.
            if (chk_row_reg && (y_reg > row_rdata))
            begin
                row_reg    <= RIW'(chk_k_reg);
                rowpos_reg <= row_rdata;
            end
            if (chk_col_reg && (x_reg > col_rdata))
            begin
                col_reg    <= CIW'(chk_k_reg);
                colpos_reg <= col_rdata;
            end
        end

        if (state_reg == ST_UV)
        begin
            mag_u_reg <= u_abs[COORD_W-1:0];
            mag_v_reg <= v_abs[COORD_W-1:0];
            su_reg    <= u_diff[COORD_W];
            sv_reg    <= v_diff[COORD_W];
        end

        if ((state_reg == ST_CORNER) && (cnt_reg != 3'd0))
        begin
            samp_c_reg[corner_idx] <= nsamp_rdata;
            line_c_reg[corner_idx] <= nline_rdata;
        end

        if (state_reg == ST_PREP)
        begin
            absa_reg <= OPA_W'(a_abs);
            absb_reg <= OPA_W'(b_abs);
            absd_reg <= d_abs[OPA_W-1:0];
            sa_reg   <= a_diff[NODE_W];
            sb_reg   <= b_diff[NODE_W];
            sd_reg   <= d_diff[NODE_W+2];
        end

        if (state_reg == ST_MAC)
        begin
            if (!ph_reg)
            begin
                prod_reg <= prod;
            end
            else
            begin
                acc_reg <= acc_sum;
            end
            if (mac_last)
            begin
                case (job_reg)
                    JOB_DXY: dxy_reg <= acc_sum[31:0];
                    JOB_P1:  p1_reg  <= acc_sum[39:0];
                    JOB_P2:  p2_reg  <= acc_sum[39:0];
                    JOB_P3:  p3_reg  <= acc_sum[47:0];
                    default: ;
                endcase
            end
        end

        if (state_reg == ST_DIVINIT)
        begin
            m_reg   <= acc_mag + half;
            neg_reg <= acc_reg[ACC_W-1];
        end
        else if (state_reg == ST_DIVCHK)
        begin
            ovf_reg <= (m_reg >= (den << QUO_W));
            dsh_reg <= den << (QUO_W - 1);
            q_reg   <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            if (div_ge)
            begin
                m_reg <= m_reg - dsh_reg;
            end
            q_reg   <= {q_reg[QUO_W-2:0], div_ge};
            dsh_reg <= dsh_reg >> 1;
        end

        if (state_reg == ST_FIN)
        begin
            if (coord_reg)
            begin
                my_reg  <= fin_val;
                sat_reg <= sat_reg || fin_sat;
            end
            else
            begin
                mx_reg  <= fin_val;
                sat_reg <= fin_sat;
            end
        end

        if (out_load)
        begin
            if (zero_reg)
            begin
                mapped_x_reg <= '0;
                mapped_y_reg <= '0;
                status_reg   <= STATUS_ZERO;
            end
            else
            begin
                mapped_x_reg <= mx_reg;
                mapped_y_reg <= my_reg;
                status_reg   <= sat_reg ? STATUS_SAT : STATUS_OK;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign mapped_x  = mapped_x_reg;
    assign mapped_y  = mapped_y_reg;
    assign status    = status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `GBM_ASSERT_NEXT(a_eval_blocks_input, clk, rst_n,
        in_valid && in_ready && (command == CMD_EVAL), !in_ready,
        "input still ready after an evaluate transfer")
    `GBM_ASSERT_SAME(a_search_in_range, clk, rst_n,
        state_reg == ST_SEARCH, k_reg <= last_reg,
        "cell search ran past its last entry")
    `GBM_ASSERT_NEXT(a_done_loads_result, clk, rst_n,
        (state_reg == ST_DONE) && (!out_valid || out_ready),
        out_valid && (state_reg == ST_IDLE),
        "finished result was not presented")
    `GBM_ASSERT_SAME(a_zero_spacing_clear, clk, rst_n,
        out_valid && (status == STATUS_ZERO), (mapped_x == 0) && (mapped_y == 0),
        "zero spacing result carries a nonzero point")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid bilinear mapper testbench
// Loads interpolation grids under several row and column counts, evaluates
// points against an in-bench bilinear predictor and checks every result.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic [1:0]         st;
} map_result_t;

// Mirror of the grid tables and counts; predicts the mapped point per evaluate.
class grid_map_scoreboard;
    logic [23:0]        row_pos[64];
    logic [23:0]        col_pos[64];
    logic signed [31:0] node_smp[64][64];
    logic signed [31:0] node_lin[64][64];
    int                 row_cnt;
    int                 col_cnt;
    map_result_t        expected_maps[$];
    int                 errors;

    function new();
        row_cnt = 2;
        col_cnt = 2;
        errors  = 0;
    endfunction

    function void set_count(logic idx, int val);
        if (idx == gbm_pkg::CFG_ROW_COUNT) row_cnt = val & 127;
        else col_cnt = val & 127;
    endfunction

    function int pending();
        return expected_maps.size();
    endfunction

    // One coordinate of the bilinear blend, computed exactly and rounded
    // half away from zero, quotient magnitude capped at 2^40.
    function longint blend(longint tl, longint tr, longint bl, longint br,
                           longint u, longint v, longint dx, longint dy,
                           inout bit sat);
        logic signed [127:0] num;
        logic signed [127:0] mag;
        logic signed [127:0] den;
        logic signed [127:0] quo;
        longint a;
        longint b;
        longint d;
        longint r;
        bit neg;
        a = tr - tl;
        b = bl - tl;
        d = br - tr - bl + tl;
        num = 128'(a) * 128'(u) * 128'(dy) * 256
            + 128'(b) * 128'(v) * 128'(dx) * 256
            + 128'(d) * 128'(u) * 128'(v);
        mag = (num < 0) ? -num : num;
        den = 128'(65536) * 128'(dx < 0 ? -dx : dx) * 128'(dy < 0 ? -dy : dy);
        quo = (mag + den / 2) / den;
        if (quo > (128'sd1 <<< 40)) quo = 128'sd1 <<< 40;
        neg = (num < 0) ^ (dx < 0) ^ (dy < 0);
        r = neg ? tl - longint'(quo) : tl + longint'(quo);
        if (r > 64'sd2147483647) begin
            sat = 1;
            r = 64'sd2147483647;
        end
        if (r < -64'sd2147483648) begin
            sat = 1;
            r = -64'sd2147483648;
        end
        return r;
    endfunction

    function void note_input(logic [1:0] cmd, logic [5:0] ri, logic [5:0] ci,
                             logic [23:0] y, logic [23:0] x,
                             logic signed [31:0] ns, logic signed [31:0] nl);
        int rc;
        int cc;
        int row;
        int col;
        longint dx;
        longint dy;
        longint u;
        longint v;
        bit sat;
        map_result_t res;
        case (gbm_pkg::cmd_t'(cmd))
            gbm_pkg::CMD_ROW_POS: row_pos[ri] = y;
            gbm_pkg::CMD_COL_POS: col_pos[ci] = x;
            gbm_pkg::CMD_NODE:
            begin
                node_smp[ri][ci] = ns;
                node_lin[ri][ci] = nl;
            end
            default:
            begin
                rc = row_cnt < 2 ? 2 : (row_cnt > 64 ? 64 : row_cnt);
                cc = col_cnt < 2 ? 2 : (col_cnt > 64 ? 64 : col_cnt);
                row = 0;
                col = 0;
                for (int k = 0; k < rc - 1; k++)
                    if (y > row_pos[k]) row = k;
                for (int k = 0; k < cc - 1; k++)
                    if (x > col_pos[k]) col = k;
                dx = (longint'(col_pos[1]) - longint'(col_pos[0])) / 256;
                dy = (longint'(row_pos[1]) - longint'(row_pos[0])) / 256;
                res = '0;
                if (dx == 0 || dy == 0) begin
                    res.st = gbm_pkg::STATUS_ZERO;
                end
                else begin
                    sat = 0;
                    u = longint'(x) - longint'(col_pos[col]);
                    v = longint'(y) - longint'(row_pos[row]);
                    res.mx = 32'(blend(node_smp[row][col], node_smp[row][col+1],
                                       node_smp[row+1][col], node_smp[row+1][col+1],
                                       u, v, dx, dy, sat));
                    res.my = 32'(blend(node_lin[row][col], node_lin[row][col+1],
                                       node_lin[row+1][col], node_lin[row+1][col+1],
                                       u, v, dx, dy, sat));
                    res.st = sat ? gbm_pkg::STATUS_SAT : gbm_pkg::STATUS_OK;
                end
                expected_maps.push_back(res);
            end
        endcase
    endfunction

    function void check_result(logic signed [31:0] mx, logic signed [31:0] my,
                               logic [1:0] st);
        map_result_t e;
        if (expected_maps.size() == 0) begin
            $error("unexpected result transfer: mapped_x %h mapped_y %h status %0d",
                   mx, my, st);
            errors++;
            return;
        end
        e = expected_maps.pop_front();
        if (mx !== e.mx) begin
            $error("mapped_x expected %h actual %h", e.mx, mx);
            errors++;
        end
        if (my !== e.my) begin
            $error("mapped_y expected %h actual %h", e.my, my);
            errors++;
        end
        if (st !== e.st) begin
            $error("status expected %0d actual %0d", e.st, st);
            errors++;
        end
    endfunction
endclass

module tb;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [0:0]         cfg_index;
    logic [6:0]         cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         command;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic [23:0]        out_coord_y;
    logic [23:0]        out_coord_x;
    logic signed [31:0] node_sample;
    logic signed [31:0] node_line;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] mapped_x;
    logic signed [31:0] mapped_y;
    logic [1:0]         status;

    grid_map_scoreboard sb = new();

    // Idle percentages for the sender and the receiver, set per phase.
    int send_idle_pct;
    int recv_stall_pct;
    // A long receiver hold-off is requested here and counted by the receiver.
    bit hold_req;
    int hold_left;

    // Current grid layout, used to aim evaluate points inside the grid.
    int eff_rows;
    int eff_cols;
    int pos_base;
    int pos_step;
    bit pos_desc;
    bit wide_nodes;

    grid_bilinear_mapper_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .row_index   (row_index),
        .col_index   (col_index),
        .out_coord_y (out_coord_y),
        .out_coord_x (out_coord_x),
        .node_sample (node_sample),
        .node_line   (node_line),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mapped_x    (mapped_x),
        .mapped_y    (mapped_y),
        .status      (status)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver: random stalls per phase, plus the long hold-off on request.
    // Out_ready is read before this edge's update, so the transfer check sees
    // the value that the block saw.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(mapped_x, mapped_y, status);
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one item and hold it until the transfer. Valid is only lowered
    // when an idle gap is inserted ahead of the item.
    task automatic send_item(logic [1:0] cmd, logic [5:0] ri, logic [5:0] ci,
                             logic [23:0] y, logic [23:0] x,
                             logic [31:0] ns, logic [31:0] nl);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 200) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        row_index   <= ri;
        col_index   <= ci;
        out_coord_y <= y;
        out_coord_x <= x;
        node_sample <= ns;
        node_line   <= nl;
        do @(posedge clk); while (!in_ready);
        sb.note_input(cmd, ri, ci, y, x, ns, nl);
    endtask

    // Wait with the input idle until every expected result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // One write, then cfg_we is dropped before the next one so that back-to-back writes never
    // drive the port twice in the same time step.
    task automatic write_count(logic idx, logic [6:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_count(idx, val);
        @(posedge clk);
    endtask

    function automatic logic [23:0] grid_pos(int i, int n);
        return 24'(pos_base + (pos_desc ? (n - 1 - i) : i) * pos_step);
    endfunction

    function automatic logic [31:0] node_value(int r, int c, bit line);
        if (wide_nodes) return $urandom;
        return 32'(line ? r * 40960 : c * 40960) + 32'($urandom_range(8191)) - 32'd4096;
    endfunction

    task automatic random_node(int r, int c);
        send_item(gbm_pkg::CMD_NODE, 6'(r), 6'(c), 24'($urandom), 24'($urandom),
                  node_value(r, c, 0), node_value(r, c, 1));
    endtask

    // Write every position and node that an evaluate can read at these counts.
    task automatic load_grid();
        for (int i = 0; i < eff_rows; i++)
            send_item(gbm_pkg::CMD_ROW_POS, 6'(i), 6'($urandom), grid_pos(i, eff_rows),
                      24'($urandom), $urandom, $urandom);
        for (int i = 0; i < eff_cols; i++)
            send_item(gbm_pkg::CMD_COL_POS, 6'($urandom), 6'(i), 24'($urandom),
                      grid_pos(i, eff_cols), $urandom, $urandom);
        for (int r = 0; r < eff_rows; r++)
            for (int c = 0; c < eff_cols; c++)
                random_node(r, c);
    endtask

    function automatic logic [23:0] aim_point(int n);
        int lo;
        int hi;
        if ($urandom_range(7) == 0) return 24'($urandom);
        lo = pos_base - 600;
        hi = pos_base + (n - 1) * pos_step + 600;
        if (lo < 0) lo = 0;
        return 24'($urandom_range(hi, lo));
    endfunction

    task automatic evaluate(logic [23:0] y, logic [23:0] x);
        send_item(gbm_pkg::CMD_EVAL, 6'($urandom), 6'($urandom), y, x, $urandom, $urandom);
    endtask

    // Mostly evaluates inside the grid, the rest rewrites of positions and
    // nodes; an occasional wild position leaves the grid unsorted.
    task automatic random_item();
        int pick;
        int idx;
        pick = $urandom_range(99);
        if (pick < 65) begin
            evaluate(aim_point(eff_rows), aim_point(eff_cols));
        end
        else if (pick < 75) begin
            idx = $urandom_range(eff_rows - 1);
            send_item(gbm_pkg::CMD_ROW_POS, 6'(idx), 6'($urandom),
                      ($urandom_range(9) == 0) ? 24'($urandom) : grid_pos(idx, eff_rows),
                      24'($urandom), $urandom, $urandom);
        end
        else if (pick < 85) begin
            idx = $urandom_range(eff_cols - 1);
            send_item(gbm_pkg::CMD_COL_POS, 6'($urandom), 6'(idx), 24'($urandom),
                      ($urandom_range(9) == 0) ? 24'($urandom) : grid_pos(idx, eff_cols),
                      $urandom, $urandom);
        end
        else begin
            // Any node may be written; ones outside the counts are simply stored.
            random_node($urandom_range(63), $urandom_range(63));
        end
    endtask

    // One phase: counts, grid layout and idling, then random traffic.
    task automatic run_phase(logic [6:0] rows, logic [6:0] cols, int step, bit desc,
                             bit wide, int n_rand, int mode);
        write_count(gbm_pkg::CFG_ROW_COUNT, rows);
        write_count(gbm_pkg::CFG_COL_COUNT, cols);
        eff_rows   = rows < 2 ? 2 : (rows > 64 ? 64 : rows);
        eff_cols   = cols < 2 ? 2 : (cols > 64 ? 64 : cols);
        pos_base   = $urandom_range(3000);
        pos_step   = step;
        pos_desc   = desc;
        wide_nodes = wide;
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
        endcase
        load_grid();
        for (int i = 0; i < n_rand; i++) begin
            random_item();
            if (mode == 2 && i == 5) hold_req = 1'b1;
            if (mode == 0 && i == n_rand / 2) drain();
        end
        drain();
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        command     <= '0;
        row_index   <= '0;
        col_index   <= '0;
        out_coord_y <= '0;
        out_coord_x <= '0;
        node_sample <= '0;
        node_line   <= '0;
        out_ready   <= 1'b0;
        hold_req     = 1'b0;
        hold_left    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Directed start at the reset counts: a 2x2 grid with full-range
        // nodes, evaluated at both coordinate extremes and inside the cell.
        eff_rows   = 2;
        eff_cols   = 2;
        pos_base   = 1000;
        pos_step   = 2560;
        pos_desc   = 0;
        wide_nodes = 1;
        load_grid();
        evaluate(24'h000000, 24'h000000);
        evaluate(24'hFFFFFF, 24'hFFFFFF);
        evaluate(24'h000000, 24'hFFFFFF);
        evaluate(24'd2280, 24'd2280);
        evaluate(24'd1000, 24'd3560);
        // Extreme nodes on every corner; the far evaluate pushes both coordinates into saturation.
        send_item(gbm_pkg::CMD_NODE, 6'd0, 6'd0, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(gbm_pkg::CMD_NODE, 6'd0, 6'd1, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(gbm_pkg::CMD_NODE, 6'd1, 6'd0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(gbm_pkg::CMD_NODE, 6'd1, 6'd1, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF);
        evaluate(24'hFFFFFF, 24'hFFFFFF);
        evaluate(24'd2000, 24'd3000);
        drain();

        // Counts below the minimum and a grid spacing under one pixel.
        run_phase(7'd0, 7'd1, 100, 0, 0, 10, 0);
        // Descending positions give negative spacing.
        run_phase(7'd3, 7'd4, 1800, 1, 0, 50, 1);
        // Counts above the maximum; a long receiver hold-off falls here, as in every mode 2 phase.
        run_phase(7'd127, 7'd2, 700, 0, 0, 60, 2);
        run_phase(7'd2, 7'd64, 900, 0, 1, 60, 3);
        run_phase(7'd5, 7'd6, 1300, 0, 0, 70, 0);
        run_phase(7'd8, 7'd3, 256, 0, 1, 70, 1);
        run_phase(7'd4, 7'd4, 3000, 0, 0, 70, 2);
        run_phase(7'd6, 7'd2, 2048, 1, 1, 60, 3);
        run_phase(7'd2, 7'd2, 511, 0, 0, 40, 0);

        repeat (300) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** grid_bilinear_mapper_top: PASSED **");
        else
            $display("** grid_bilinear_mapper_top: FAILED **");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("** grid_bilinear_mapper_top: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/gbm_pkg.sv
rtl/gbm_ram.sv
rtl/grid_bilinear_mapper_top.sv
sim/tb.sv
